### design/ust_pkg.sv
// ust_pkg: shared types and constants of the unique id slot table
// opcodes, controller states, cell chain and cell control structs
// no dependencies
package ust_pkg;

    // default parameter values
    localparam int DEF_SLOTS   = 8;
    localparam int DEF_ID_BITS = 16;

    // fixed field widths of the transfer payloads
    localparam int SLOT_FIELD_W = 8;
    localparam int ID_FIELD_W   = 16;
    localparam int OP_W         = 3;
    localparam int FOUND_W      = 3;
    localparam int OCC_W        = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SET    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_SWAP   = 3'd4,
        OP_FIND   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WRITE
    } t_state;

    // priority flags rippling from cell to cell
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } t_chain;

    // write strobes broadcast to every cell
    typedef struct packed {
        logic wr_first;
        logic wr_second;
    } t_cell_ctl;

endpackage

### design/ust_if.sv
// ust_if: valid/ready channel interfaces of the unique id slot table
// request channel and response channel, payload widths from ust_pkg
// depends on ust_pkg
interface ust_in_if;
    logic                              valid;
    logic                              ready;
    logic [ust_pkg::OP_W-1:0]          operation;
    logic [ust_pkg::SLOT_FIELD_W-1:0]  slot_first;
    logic [ust_pkg::SLOT_FIELD_W-1:0]  slot_second;
    logic [ust_pkg::ID_FIELD_W-1:0]    unit_id;

    modport source (output valid, output operation, output slot_first,
                    output slot_second, output unit_id, input ready);
    modport sink   (input valid, input operation, input slot_first,
                    input slot_second, input unit_id, output ready);
endinterface

interface ust_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [ust_pkg::FOUND_W-1:0]    slot_found;
    logic [ust_pkg::ID_FIELD_W-1:0] unit_out;
    logic [ust_pkg::OCC_W-1:0]      occupied;
    logic                           table_full;

    modport source (output valid, output accepted, output slot_found,
                    output unit_out, output occupied, output table_full,
                    input ready);
    modport sink   (input valid, input accepted, input slot_found,
                    input unit_out, input occupied, input table_full,
                    output ready);
endinterface

### design/ust_cell.sv
// ust_cell: one slot of the table with its compare and priority logic
// hands hit and free flags on to the next cell of the chain
// depends on ust_pkg
module ust_cell #(
    parameter int CELL_IDX = 0,
    parameter int ID_W     = 16,
    parameter int SW       = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ust_pkg::t_chain    i_chain,
    output ust_pkg::t_chain    o_chain,
    input  logic [ID_W-1:0]    i_id,
    input  logic [SW-1:0]      i_rd_first_idx,
    input  logic [SW-1:0]      i_rd_second_idx,
    input  ust_pkg::t_cell_ctl i_ctl,
    input  logic [SW-1:0]      i_wr_first_idx,
    input  logic [ID_W-1:0]    i_wr_first_data,
    input  logic [SW-1:0]      i_wr_second_idx,
    input  logic [ID_W-1:0]    i_wr_second_data,
    output logic               o_hit,
    output logic               o_free,
    output logic               o_used,
    output logic [ID_W-1:0]    o_rd_first,
    output logic [ID_W-1:0]    o_rd_second
);

    localparam logic [SW-1:0] MY_IDX = SW'(CELL_IDX);

    logic [ID_W-1:0] r_data;
    logic [ID_W-1:0] n_data;
    logic            w_match;
    logic            w_empty;

    // a zero id never matches, empty slots hold zero
    assign w_match = (r_data == i_id) && (i_id != '0);
    assign w_empty = (r_data == '0);

    assign o_hit   = w_match && !i_chain.hit_seen;
    assign o_free  = w_empty && !i_chain.free_seen;
    assign o_used  = !w_empty;
    assign o_chain = '{hit_seen:  i_chain.hit_seen  || w_match,
                       free_seen: i_chain.free_seen || w_empty};

    // shared read buses, or-ed across cells
    assign o_rd_first  = (i_rd_first_idx  == MY_IDX) ? r_data : '0;
    assign o_rd_second = (i_rd_second_idx == MY_IDX) ? r_data : '0;

    always_comb begin
        n_data = r_data;
        if (i_ctl.wr_first && (i_wr_first_idx == MY_IDX)) begin
            n_data = i_wr_first_data;
        end else if (i_ctl.wr_second && (i_wr_second_idx == MY_IDX)) begin
            n_data = i_wr_second_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

endmodule

### design/unique_id_slot_table_top.sv
// unique_id_slot_table_top: table of unique nonzero ids held in a chain of cells
// controller, lookup registers, occupancy counter and response register
// depends on ust_pkg, ust_if (ust_in_if, ust_out_if) and ust_cell
//
// The table holds SLOTS slots, each empty (zero) or holding a nonzero id no
// other slot holds; reset empties every slot. Each request transfer gives
// exactly one response transfer. After the accepting edge a lookup state
// runs the compare and priority chain through the cells and registers the
// first hit, the first empty slot and the two read slots; in the write
// state that follows, the decision is made, the cells are written and the
// response register is loaded, and the next request can be accepted at that
// same edge. A new request is not taken while an item is in the lookup
// state, held off by the registers between the cell chain and the write
// decision. A response waiting in the output register holds the write
// cycle until it is taken. Occupancy is kept in a counter updated with each
// write, not recounted.
module unique_id_slot_table_top #(
    parameter int SLOTS   = ust_pkg::DEF_SLOTS,
    parameter int ID_BITS = ust_pkg::DEF_ID_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ust_in_if.sink    i_req,
    ust_out_if.source o_rsp
);

    // stored id width: the request field caps it
    localparam int ID_W = (ID_BITS < ust_pkg::ID_FIELD_W) ? ID_BITS : ust_pkg::ID_FIELD_W;
    // slot index width, at least one bit
    localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // counter width, holds SLOTS itself
    localparam int CW   = $clog2(SLOTS + 1);
    localparam logic [ust_pkg::SLOT_FIELD_W:0] SLOT_LIM = (ust_pkg::SLOT_FIELD_W + 1)'(SLOTS);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    // controller
    ust_pkg::t_state r_state;
    ust_pkg::t_state n_state;
    logic            w_out_free;
    logic            w_in_ready;
    logic            w_in_xfer;
    logic            w_commit;

    // request held for the item at work
    logic [ust_pkg::OP_W-1:0]         r_op;
    logic [ust_pkg::SLOT_FIELD_W-1:0] r_a;
    logic [ust_pkg::SLOT_FIELD_W-1:0] r_b;
    logic [ID_W-1:0]                  r_id;

    // lookup results, loaded in the lookup cycle
    logic            r_hit_any;
    logic [SW-1:0]   r_hit_idx;
    logic            r_free_any;
    logic [SW-1:0]   r_free_idx;
    logic [ID_W-1:0] r_rd_a;
    logic [ID_W-1:0] r_rd_b;

    // cell chain wiring
    ust_pkg::t_chain    w_chain [SLOTS+1];
    ust_pkg::t_cell_ctl w_ctl;
    logic [SLOTS-1:0]   w_hit_vec;
    logic [SLOTS-1:0]   w_free_vec;
    logic [SLOTS-1:0]   w_used_vec;
    logic [ID_W-1:0]    w_rd_first  [SLOTS];
    logic [ID_W-1:0]    w_rd_second [SLOTS];

    // reductions over the cells
    logic            w_hit_any;
    logic [SW-1:0]   w_hit_idx;
    logic            w_free_any;
    logic [SW-1:0]   w_free_idx;
    logic [ID_W-1:0] w_rd_a;
    logic [ID_W-1:0] w_rd_b;

    // write decision
    logic                w_a_ok;
    logic                w_b_ok;
    logic                w_id_nz;
    logic                w_acc;
    logic [SW-1:0]       w_found;
    logic [ID_W-1:0]     w_uout;
    logic                w_wr_first;
    logic                w_wr_second;
    logic [SW-1:0]       w_wr_first_idx;
    logic [ID_W-1:0]     w_wr_first_data;
    logic [SW-1:0]       w_wr_second_idx;
    logic [ID_W-1:0]     w_wr_second_data;
    logic                w_cnt_inc;
    logic                w_cnt_dec;

    // occupancy counter
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // response register
    logic                               r_out_valid;
    logic                               r_out_acc;
    logic [ust_pkg::FOUND_W-1:0]        r_out_found;
    logic [ust_pkg::ID_FIELD_W-1:0]     r_out_unit;
    logic [ust_pkg::OCC_W-1:0]          r_out_occ;
    logic                               r_out_full;

    // ---------------------------------------------------------------
    // controller: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ust_pkg::ST_IDLE: begin
                if (w_in_xfer) n_state = ust_pkg::ST_LOOK;
            end
            ust_pkg::ST_LOOK: begin
                n_state = ust_pkg::ST_WRITE;
            end
            ust_pkg::ST_WRITE: begin
                // a fresh transfer can start while this one retires
                if (w_out_free) n_state = w_in_xfer ? ust_pkg::ST_LOOK : ust_pkg::ST_IDLE;
            end
            default: begin
                n_state = ust_pkg::ST_IDLE;
            end
        endcase
    end

    // controller: outputs
    always_comb begin
        w_out_free = !r_out_valid || o_rsp.ready;
        w_in_ready = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            ust_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ust_pkg::ST_LOOK: begin
                w_in_ready = 1'b0;
            end
            ust_pkg::ST_WRITE: begin
                w_in_ready = w_out_free;
                w_commit   = w_out_free;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = w_in_ready;
    assign w_in_xfer   = i_req.valid && w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ust_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture, payload only
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op <= i_req.operation;
            r_a  <= i_req.slot_first;
            r_b  <= i_req.slot_second;
            r_id <= i_req.unit_id[ID_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // chain of cells
    // ---------------------------------------------------------------
    assign w_chain[0] = '0;
    assign w_ctl      = '{wr_first: w_commit && w_wr_first, wr_second: w_commit && w_wr_second};

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ust_cell #(
            .CELL_IDX (g),
            .ID_W     (ID_W),
            .SW       (SW)
        ) u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_chain          (w_chain[g]),
            .o_chain          (w_chain[g+1]),
            .i_id             (r_id),
            .i_rd_first_idx   (r_a[SW-1:0]),
            .i_rd_second_idx  (r_b[SW-1:0]),
            .i_ctl            (w_ctl),
            .i_wr_first_idx   (w_wr_first_idx),
            .i_wr_first_data  (w_wr_first_data),
            .i_wr_second_idx  (w_wr_second_idx),
            .i_wr_second_data (w_wr_second_data),
            .o_hit            (w_hit_vec[g]),
            .o_free           (w_free_vec[g]),
            .o_used           (w_used_vec[g]),
            .o_rd_first       (w_rd_first[g]),
            .o_rd_second      (w_rd_second[g])
        );
    end

    // first hit and first free are one-hot, so an or of indexes encodes them
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        w_rd_a     = '0;
        w_rd_b     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_hit_vec[i])  w_hit_idx  = w_hit_idx  | SW'(i);
            if (w_free_vec[i]) w_free_idx = w_free_idx | SW'(i);
            w_rd_a = w_rd_a | w_rd_first[i];
            w_rd_b = w_rd_b | w_rd_second[i];
        end
    end

    assign w_hit_any  = w_chain[SLOTS].hit_seen;
    assign w_free_any = w_chain[SLOTS].free_seen;

    always_ff @(posedge i_clk) begin
        if (r_state == ust_pkg::ST_LOOK) begin
            r_hit_any  <= w_hit_any;
            r_hit_idx  <= w_hit_idx;
            r_free_any <= w_free_any;
            r_free_idx <= w_free_idx;
            r_rd_a     <= w_rd_a;
            r_rd_b     <= w_rd_b;
        end
    end

    // ---------------------------------------------------------------
    // write decision
    // ---------------------------------------------------------------
    assign w_a_ok  = ({1'b0, r_a} < SLOT_LIM);
    assign w_b_ok  = ({1'b0, r_b} < SLOT_LIM);
    assign w_id_nz = (r_id != '0);

    always_comb begin
        w_acc            = 1'b0;
        w_found          = '0;
        w_uout           = '0;
        w_wr_first       = 1'b0;
        w_wr_second      = 1'b0;
        w_wr_first_idx   = r_a[SW-1:0];
        w_wr_first_data  = r_id;
        w_wr_second_idx  = r_b[SW-1:0];
        w_wr_second_data = r_rd_a;
        w_cnt_inc        = 1'b0;
        w_cnt_dec        = 1'b0;
        unique case (ust_pkg::t_op'(r_op))
            ust_pkg::OP_ADD: begin
                // lowest empty slot, refused when the id is zero, present or the table is full
                if (w_id_nz && !r_hit_any && r_free_any) begin
                    w_acc          = 1'b1;
                    w_found        = r_free_idx;
                    w_wr_first     = 1'b1;
                    w_wr_first_idx = r_free_idx;
                    w_cnt_inc      = 1'b1;
                end
            end
            ust_pkg::OP_SET: begin
                // rewriting the slot that holds the id is allowed
                if (w_a_ok && w_id_nz && (!r_hit_any || (r_hit_idx == r_a[SW-1:0]))) begin
                    w_acc      = 1'b1;
                    w_wr_first = 1'b1;
                    w_cnt_inc  = (r_rd_a == '0);
                end
            end
            ust_pkg::OP_REMOVE: begin
                if (w_a_ok) begin
                    w_acc           = 1'b1;
                    w_uout          = r_rd_a;
                    w_wr_first      = 1'b1;
                    w_wr_first_data = '0;
                    w_cnt_dec       = (r_rd_a != '0);
                end
            end
            ust_pkg::OP_GET: begin
                if (w_a_ok) begin
                    w_acc  = 1'b1;
                    w_uout = r_rd_a;
                end
            end
            ust_pkg::OP_SWAP: begin
                // same slot twice writes its own content back
                if (w_a_ok && w_b_ok) begin
                    w_acc           = 1'b1;
                    w_wr_first      = 1'b1;
                    w_wr_first_data = r_rd_b;
                    w_wr_second     = 1'b1;
                end
            end
            ust_pkg::OP_FIND: begin
                if (r_hit_any) begin
                    w_acc   = 1'b1;
                    w_found = r_hit_idx;
                end
            end
            default: begin
                w_acc = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // occupancy counter
    // ---------------------------------------------------------------
    always_comb begin
        n_count = r_count;
        if (w_cnt_inc)      n_count = r_count + CW'(1);
        else if (w_cnt_dec) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    // ---------------------------------------------------------------
    // response register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_acc   <= w_acc;
            r_out_found <= ust_pkg::FOUND_W'({{ust_pkg::FOUND_W{1'b0}}, w_found});
            r_out_unit  <= ust_pkg::ID_FIELD_W'({{ust_pkg::ID_FIELD_W{1'b0}}, w_uout});
            r_out_occ   <= ust_pkg::OCC_W'({{ust_pkg::OCC_W{1'b0}}, n_count});
            r_out_full  <= (n_count == FULL_CNT);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.accepted   = r_out_acc;
    assign o_rsp.slot_found = r_out_found;
    assign o_rsp.unit_out   = r_out_unit;
    assign o_rsp.occupied   = r_out_occ;
    assign o_rsp.table_full = r_out_full;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // counter tracks the slots actually in use
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(w_used_vec)))
        else $error("occupancy counter out of step with cells");

    // priority chain yields at most one hit and one free slot in the lookup cycle
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ust_pkg::ST_LOOK) |-> ($onehot0(w_hit_vec) && $onehot0(w_free_vec)))
        else $error("priority chain gave more than one winner");

    // an accepted request always moves into the lookup cycle
    a_xfer_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ust_pkg::ST_LOOK))
        else $error("request transfer not followed by lookup");

    // a retiring item always leaves a response behind
    a_commit_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("write cycle left no response");

    // cells are written only when the response register can take the result
    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.wr_first || w_ctl.wr_second) |-> (r_state == ust_pkg::ST_WRITE && w_out_free))
        else $error("cell write outside a retiring write cycle");

endmodule

### dv/unique_id_slot_table_checker.sv
// unique_id_slot_table_checker: watches both channels of the slot table, checks each response
// keeps a shadow copy of the slots and predicts each response when its request transfers
// depends on ust_pkg and ust_if (ust_in_if, ust_out_if)
module unique_id_slot_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ust_in_if    i_req_mon,
    ust_out_if   i_rsp_mon,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = ust_pkg::DEF_SLOTS;
    localparam int ID_BITS      = ust_pkg::DEF_ID_BITS;
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REPORT_LIMIT = 10;

    typedef logic [ID_BITS-1:0] t_id;

    typedef struct packed {
        logic                           accepted;
        logic [ust_pkg::FOUND_W-1:0]    slot_found;
        logic [ust_pkg::ID_FIELD_W-1:0] unit_out;
        logic [ust_pkg::OCC_W-1:0]      occupied;
        logic                           table_full;
    } t_table_result;

    t_id           shadow_slots [SLOTS];
    t_table_result expected_results [$];

    // lowest slot holding id, -1 when absent or id is zero
    function automatic int lookup_id(t_id id);
        int hit;
        hit = -1;
        if (id != '0) begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (shadow_slots[i] == id) hit = i;
            end
        end
        return hit;
    endfunction

    // applies one operation to the shadow slots and returns the response it should give
    function automatic t_table_result apply_table_op(
        logic [ust_pkg::OP_W-1:0]         op,
        logic [ust_pkg::SLOT_FIELD_W-1:0] first,
        logic [ust_pkg::SLOT_FIELD_W-1:0] second,
        logic [ust_pkg::ID_FIELD_W-1:0]   raw_id);
        t_table_result    res;
        t_id              id;
        t_id              held;
        logic             first_ok;
        logic             second_ok;
        logic [IDX_W-1:0] fi;
        logic [IDX_W-1:0] si;
        int               s;
        int               used;
        res       = '0;
        id        = raw_id[ID_BITS-1:0];
        first_ok  = (int'(first) < SLOTS);
        second_ok = (int'(second) < SLOTS);
        fi        = first[IDX_W-1:0];
        si        = second[IDX_W-1:0];
        case (op) inside
            ust_pkg::OP_ADD: begin
                if (id != '0 && lookup_id(id) < 0) begin
                    s = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (shadow_slots[i] == '0) s = i;
                    end
                    if (s >= 0) begin
                        shadow_slots[s] = id;
                        res.accepted    = 1'b1;
                        res.slot_found  = s[ust_pkg::FOUND_W-1:0];
                    end
                end
            end
            ust_pkg::OP_SET: begin
                if (first_ok && id != '0) begin
                    s = lookup_id(id);
                    if (s < 0 || s == int'(first)) begin
                        shadow_slots[fi] = id;
                        res.accepted     = 1'b1;
                    end
                end
            end
            ust_pkg::OP_REMOVE, ust_pkg::OP_GET: begin
                if (first_ok) begin
                    res.unit_out = ust_pkg::ID_FIELD_W'(shadow_slots[fi]);
                    res.accepted = 1'b1;
                    if (op == ust_pkg::OP_REMOVE) shadow_slots[fi] = '0;
                end
            end
            ust_pkg::OP_SWAP: begin
                if (first_ok && second_ok) begin
                    held             = shadow_slots[fi];
                    shadow_slots[fi] = shadow_slots[si];
                    shadow_slots[si] = held;
                    res.accepted     = 1'b1;
                end
            end
            ust_pkg::OP_FIND: begin
                s = lookup_id(id);
                if (s >= 0) begin
                    res.accepted   = 1'b1;
                    res.slot_found = s[ust_pkg::FOUND_W-1:0];
                end
            end
            default: ;
        endcase
        used = 0;
        foreach (shadow_slots[i]) begin
            if (shadow_slots[i] != '0) used++;
        end
        res.occupied   = used[ust_pkg::OCC_W-1:0];
        res.table_full = (used == SLOTS);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_table_result got;
        t_table_result want;
        logic          bad;
        if (!i_rst_n) begin
            foreach (shadow_slots[i]) shadow_slots[i] = '0;
            expected_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
            o_full_seen  = 0;
        end else begin
            // a response can never belong to a request taken at the same edge
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got.accepted   = i_rsp_mon.accepted;
                got.slot_found = i_rsp_mon.slot_found;
                got.unit_out   = i_rsp_mon.unit_out;
                got.occupied   = i_rsp_mon.occupied;
                got.table_full = i_rsp_mon.table_full;
                o_checked++;
                if (got.table_full === 1'b1) o_full_seen++;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("%0t: response %0d arrived with no request outstanding",
                                 $realtime, o_checked);
                end else begin
                    want = expected_results.pop_front();
                    bad  = (got.accepted !== want.accepted)
                        || (got.slot_found !== want.slot_found)
                        || (got.unit_out !== want.unit_out)
                        || (got.occupied !== want.occupied)
                        || (got.table_full !== want.table_full);
                    if (bad) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%0t: response %0d mismatch: expected acc=%0b slot=%0d unit=%h occ=%0d full=%0b",
                                     $realtime, o_checked,
                                     want.accepted, want.slot_found, want.unit_out,
                                     want.occupied, want.table_full);
                            $display("%0t: response %0d mismatch: got      acc=%0b slot=%0d unit=%h occ=%0d full=%0b",
                                     $realtime, o_checked,
                                     got.accepted, got.slot_found, got.unit_out,
                                     got.occupied, got.table_full);
                        end
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready)
                expected_results.push_back(apply_table_op(i_req_mon.operation,
                                                          i_req_mon.slot_first,
                                                          i_req_mon.slot_second,
                                                          i_req_mon.unit_id));
        end
        o_pending = expected_results.size();
    end

endmodule

### dv/unique_id_slot_table_top_tb.sv
// unique_id_slot_table_top_tb: stimulus, clock, reset and verdict for the slot table
// drives directed then random requests with random idling on both channels
// depends on ust_pkg, ust_if, unique_id_slot_table_top and unique_id_slot_table_checker
module unique_id_slot_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // opcodes the block does not define, expected to change nothing
    localparam logic [ust_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [ust_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1000;
    // no transfer on either channel for this long means the block has hung;
    // a correct run never gets near it, even with the longest random gaps
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_EDGES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;    // while set neither side idles

    int mismatches;
    int pending;
    int checked;
    int full_seen;
    int stall_cycles;

    ust_in_if  req_if ();
    ust_out_if rsp_if ();

    unique_id_slot_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    unique_id_slot_table_checker table_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen)
    );

    always #6 i_clk = ~i_clk;

    // response side: stalls in about a fifth of the cycles, never while steady
    always @(negedge i_clk) begin
        rsp_if.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                         $realtime, stall_cycles, pending);
                $display("FAIL");
                $finish;
            end
        end
    end

    // mostly a small pool of ids so that duplicates, finds and full tables are common
    function automatic logic [ust_pkg::ID_FIELD_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)  return '0;
        if (roll < 75) return ust_pkg::ID_FIELD_W'($urandom_range(1, 12));
        if (roll < 85) return 16'hFFFF ^ ust_pkg::ID_FIELD_W'($urandom_range(0, 3));
        return ust_pkg::ID_FIELD_W'($urandom_range(1, 65535));
    endfunction

    // mostly valid slots, sometimes anything up to the field maximum
    function automatic logic [ust_pkg::SLOT_FIELD_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 85)
            return ust_pkg::SLOT_FIELD_W'($urandom_range(0, ust_pkg::DEF_SLOTS - 1));
        return ust_pkg::SLOT_FIELD_W'($urandom_range(ust_pkg::DEF_SLOTS, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_req(input logic [ust_pkg::OP_W-1:0] op,
                            input logic [ust_pkg::SLOT_FIELD_W-1:0] first,
                            input logic [ust_pkg::SLOT_FIELD_W-1:0] second,
                            input logic [ust_pkg::ID_FIELD_W-1:0] id);
        if (!steady) begin
            while ($urandom_range(0, 99) < 20) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.slot_first  <= first;
        req_if.slot_second <= second;
        req_if.unit_id     <= id;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int                        n_directed;
        int                        roll;
        int                        add_cut;
        int                        set_cut;
        int                        remove_cut;
        logic [ust_pkg::OP_W-1:0]  op;

        i_rst_n            = 1'b0;
        steady             = 1'b0;
        req_if.valid       = 1'b0;
        req_if.operation   = ust_pkg::OP_GET;
        req_if.slot_first  = '0;
        req_if.slot_second = '0;
        req_if.unit_id     = '0;
        rsp_if.ready       = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_req(ust_pkg::OP_GET, 8'd0, 8'd0, 16'h0000);      // empty slot reads as zero
        send_req(ust_pkg::OP_ADD, 8'd0, 8'd0, 16'h0000);      // zero id refused
        send_req(ust_pkg::OP_ADD, 8'd0, 8'd0, 16'hFFFF);      // widest id into slot 0
        send_req(ust_pkg::OP_ADD, 8'd0, 8'd0, 16'hFFFF);      // duplicate refused
        send_req(ust_pkg::OP_ADD, 8'd0, 8'd0, 16'h0001);
        send_req(ust_pkg::OP_FIND, 8'd0, 8'd0, 16'hFFFF);
        send_req(ust_pkg::OP_FIND, 8'd0, 8'd0, 16'h0000);     // zero never matches
        send_req(ust_pkg::OP_FIND, 8'd0, 8'd0, 16'h1234);     // absent id
        send_req(ust_pkg::OP_SET, 8'd7, 8'd0, 16'h8000);
        send_req(ust_pkg::OP_SET, 8'd255, 8'd0, 16'h0005);    // slot out of range
        send_req(ust_pkg::OP_SET, 8'd2, 8'd0, 16'h0000);      // zero id refused
        send_req(ust_pkg::OP_SET, 8'd2, 8'd0, 16'h0001);      // id already held elsewhere
        send_req(ust_pkg::OP_SET, 8'd1, 8'd0, 16'h0001);      // same id at its own slot
        send_req(ust_pkg::OP_SET, 8'd7, 8'd0, 16'h0002);      // overwrite
        send_req(ust_pkg::OP_SWAP, 8'd0, 8'd7, 16'h0000);
        send_req(ust_pkg::OP_SWAP, 8'd3, 8'd255, 16'h0000);   // second slot out of range
        send_req(ust_pkg::OP_REMOVE, 8'd8, 8'd0, 16'h0000);   // just past the last slot
        send_req(ust_pkg::OP_REMOVE, 8'd0, 8'd0, 16'h0000);
        send_req(ust_pkg::OP_GET, 8'd255, 8'd255, 16'hFFFF);
        send_req(OP_UNUSED_LO, 8'd1, 8'd2, 16'h0003);
        send_req(OP_UNUSED_HI, 8'd1, 8'd2, 16'h0003);
        // fill the table, the last add finds it full
        for (int k = 0; k < 7; k++)
            send_req(ust_pkg::OP_ADD, 8'd0, 8'd0, 16'h0100 + ust_pkg::ID_FIELD_W'(k));
        n_directed = 28;

        // random part: blocks lean towards filling or draining the table
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    add_cut = 35; set_cut = 48; remove_cut = 56;
                end else begin
                    add_cut = 10; set_cut = 22; remove_cut = 60;
                end
            end
            steady = (n >= 300 && n < 450);
            roll   = $urandom_range(0, 99);
            if (roll < add_cut)         op = ust_pkg::OP_ADD;
            else if (roll < set_cut)    op = ust_pkg::OP_SET;
            else if (roll < remove_cut) op = ust_pkg::OP_REMOVE;
            else if (roll < 70)         op = ust_pkg::OP_GET;
            else if (roll < 82)         op = ust_pkg::OP_SWAP;
            else if (roll < 97)         op = ust_pkg::OP_FIND;
            else                        op = ($urandom_range(0, 1) == 1) ? OP_UNUSED_HI
                                                                         : OP_UNUSED_LO;
            send_req(op, pick_slot(), pick_slot(), pick_id());
        end
        steady       = 1'b0;
        req_if.valid <= 1'b0;

        // drain, then a few more edges for anything spurious
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_EDGES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed, %0d random), %0d responses checked",
                 n_directed + RANDOM_ITEMS, n_directed, RANDOM_ITEMS, checked);
        $display("table reported full in %0d responses, %0d mismatches, %0d still outstanding",
                 full_seen, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
